// ----- sv/gsp_pkg.sv -----
// ----------------------------------------------------------------------------
// gsp_pkg
// Types, protocol bytes and command codes shared by the gamepad poll responder.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int IDX_W          = 5;   // width of the reported frame index
  localparam int DIGITAL_LENGTH = 5;
  localparam int CONFIG_LENGTH  = 9;

  localparam logic [7:0] IDLE_BYTE    = 8'hFF;
  localparam logic [7:0] HEADER_ID    = 8'h5A;
  localparam logic [7:0] MODE_ANALOG  = 8'h79;
  localparam logic [7:0] MODE_DIGITAL = 8'h41;
  localparam logic [7:0] MODE_CONFIG  = 8'hF3;

  localparam logic [7:0] CMD_POLL_START   = 8'h01;
  localparam logic [7:0] CMD_QUERY_MASK   = 8'h41;
  localparam logic [7:0] CMD_CONFIG       = 8'h43;
  localparam logic [7:0] CMD_SET_MODE     = 8'h44;
  localparam logic [7:0] CMD_QUERY_MODEL  = 8'h45;
  localparam logic [7:0] CMD_QUERY_ACT    = 8'h46;
  localparam logic [7:0] CMD_QUERY_COMB   = 8'h47;
  localparam logic [7:0] CMD_QUERY_MODE   = 8'h4C;
  localparam logic [7:0] CMD_MAP_MOTOR    = 8'h4D;
  localparam logic [7:0] CMD_SET_PRESSURE = 8'h4F;

  typedef enum logic [1:0] {
    OP_FRAME_START   = 2'd0,
    OP_RX_BYTE       = 2'd1,
    OP_ATTN_RELEASE  = 2'd2,
    OP_DATA_UPDATE   = 2'd3
  } gsp_op_e;

  typedef struct packed {
    gsp_op_e    opcode;
    logic [7:0] cmd_byte;
    logic [7:0] buttons_low;
    logic [7:0] buttons_high;
    logic [7:0] right_stick_x;
    logic [7:0] right_stick_y;
    logic [7:0] left_stick_x;
    logic [7:0] left_stick_y;
  } gsp_item_t;

  typedef struct packed {
    logic [7:0]       reply_byte;
    logic             reply_load;
    logic             ack_pulse;
    logic [IDX_W-1:0] frame_index;
    logic             in_config;
  } gsp_result_t;

  // reply bytes 3 to 8; entry 0 is byte 3
  typedef logic [5:0][7:0] gsp_table_t;

  localparam gsp_table_t TABLE_RESET = {8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'hFF, 8'hFF};

  function automatic gsp_table_t tbl6(logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                      logic [7:0] b6, logic [7:0] b7, logic [7:0] b8);
    return {b8, b7, b6, b5, b4, b3};
  endfunction

endpackage

// ----- sv/gsp_in_stage.sv -----
// ----------------------------------------------------------------------------
// gsp_in_stage
// Input register: holds one accepted item until the engine takes it.
// ----------------------------------------------------------------------------
module gsp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gsp_pkg::gsp_item_t item_i,
  input  logic               take_i,
  output logic               valid_o,
  output gsp_pkg::gsp_item_t item_o
);
  import gsp_pkg::*;

  logic      valid_q;
  gsp_item_t item_q;

  assign in_stall_o = valid_q && !take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- sv/gsp_engine.sv -----
// ----------------------------------------------------------------------------
// gsp_engine
// Frame state, command decode and reply table; one item per step.
// ----------------------------------------------------------------------------
module gsp_engine #(
  parameter int FULL_LENGTH = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  gsp_pkg::gsp_item_t   item_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  output logic                 has_result_o,
  output gsp_pkg::gsp_result_t result_o
);
  import gsp_pkg::*;

  localparam int PosRaw = $clog2(FULL_LENGTH + 1);
  localparam int PosW   = (PosRaw > IDX_W) ? PosRaw : IDX_W;

  localparam logic [PosW-1:0] FullLen = PosW'(FULL_LENGTH);
  localparam logic [PosW-1:0] DigLen  = PosW'(DIGITAL_LENGTH);
  localparam logic [PosW-1:0] CfgLen  = PosW'(CONFIG_LENGTH);

  logic              allow_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [7:0]        cmd_q, cmd_d;
  logic              cfg_q, cfg_d;
  logic              digital_q, digital_d;
  logic [PosW-1:0]   frame_len_q, frame_len_d;
  gsp_table_t        table_q, table_d;

  logic [7:0]        mode_byte;
  logic [PosW-1:0]   data_len;
  logic [PosW:0]     pos_inc;
  logic              send;

  function automatic logic [7:0] byte_at(logic [PosW-1:0] pos, gsp_table_t tbl);
    logic [7:0] b;
    case (pos)
      PosW'(2): b = HEADER_ID;
      PosW'(3): b = tbl[0];
      PosW'(4): b = tbl[1];
      PosW'(5): b = tbl[2];
      PosW'(6): b = tbl[3];
      PosW'(7): b = tbl[4];
      PosW'(8): b = tbl[5];
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

  assign mode_byte = digital_q ? MODE_DIGITAL : MODE_ANALOG;
  assign data_len  = digital_q ? DigLen : FullLen;
  assign pos_inc   = {1'b0, pos_q} + (PosW+1)'(1);

  always_comb begin
    pos_d       = pos_q;
    cmd_d       = cmd_q;
    cfg_d       = cfg_q;
    digital_d   = digital_q;
    frame_len_d = frame_len_q;
    table_d     = table_q;
    send        = 1'b0;
    result_o    = '0;
    has_result_o = (item_i.opcode != OP_DATA_UPDATE);

    unique case (item_i.opcode)
      OP_FRAME_START: begin
        pos_d = '0;
        result_o.reply_byte = IDLE_BYTE;
        result_o.reply_load = 1'b1;
      end
      OP_ATTN_RELEASE: begin
        pos_d = '0;
        result_o.reply_load = 1'b1;
      end
      OP_DATA_UPDATE: begin
        table_d = tbl6(~item_i.buttons_low, ~item_i.buttons_high,
                       item_i.right_stick_x, item_i.right_stick_y,
                       item_i.left_stick_x, item_i.left_stick_y);
      end
      OP_RX_BYTE: begin
        if (pos_q == '0) begin
          // bad start byte: nothing loaded, state kept
          if (item_i.cmd_byte == CMD_POLL_START) begin
            frame_len_d = cfg_q ? CfgLen : data_len;
            pos_d       = PosW'(1);
            result_o.reply_byte = cfg_q ? MODE_CONFIG : mode_byte;
            result_o.reply_load = 1'b1;
            result_o.ack_pulse  = 1'b1;
          end
        end else begin
          if (pos_q == PosW'(1)) begin
            cmd_d = item_i.cmd_byte;
            send  = 1'b1;
          end else if (pos_q == PosW'(2)) begin
            send = 1'b1;
            unique case (cmd_q) inside
              CMD_QUERY_MASK:   table_d = digital_q ? '0 :
                                  tbl6(8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h5A);
              CMD_QUERY_MODEL:  table_d = tbl6(8'h03, 8'h02, 8'h01, 8'h02, 8'h01, 8'h00);
              CMD_QUERY_ACT, CMD_QUERY_MODE: table_d[0] = 8'h00;
              CMD_QUERY_COMB:   table_d = tbl6(8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00);
              CMD_MAP_MOTOR:    table_d = tbl6(8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
              CMD_SET_PRESSURE: table_d = tbl6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A);
              default:          send = 1'b0;
            endcase
          end else if (pos_q == PosW'(3)) begin
            send = 1'b1;
            unique case (cmd_q) inside
              CMD_CONFIG:   cfg_d = (item_i.cmd_byte == 8'h01);
              CMD_SET_MODE: digital_d = allow_q && (item_i.cmd_byte == 8'h00);
              CMD_QUERY_ACT: begin
                if (item_i.cmd_byte == 8'h00) begin
                  table_d = tbl6(table_q[0], 8'h00, 8'h00, 8'h02, 8'h00, 8'h0A);
                end else if (item_i.cmd_byte == 8'h01) begin
                  table_d = tbl6(table_q[0], 8'h00, 8'h00, 8'h00, 8'h00, 8'h14);
                end
              end
              CMD_QUERY_MODE: begin
                if (item_i.cmd_byte == 8'h00) begin
                  table_d = tbl6(table_q[0], 8'h00, 8'h00, 8'h04, 8'h00, 8'h00);
                end else if (item_i.cmd_byte == 8'h01) begin
                  table_d = tbl6(table_q[0], 8'h00, 8'h00, 8'h06, 8'h00, 8'h00);
                end
              end
              default: send = 1'b0;
            endcase
          end

          if (send || (pos_inc < {1'b0, frame_len_q})) begin
            pos_d = pos_inc[PosW-1:0];
            result_o.reply_byte = byte_at(pos_d, table_d);
            result_o.reply_load = 1'b1;
            result_o.ack_pulse  = 1'b1;
          end else if (pos_inc == {1'b0, frame_len_q}) begin
            // last byte of the frame: reply loaded, no acknowledge
            pos_d = pos_inc[PosW-1:0];
            result_o.reply_byte = byte_at(pos_d, table_d);
            result_o.reply_load = 1'b1;
          end else begin
            pos_d = '0;   // overrun
          end
        end
      end
    endcase

    result_o.frame_index = pos_d[IDX_W-1:0];
    result_o.in_config   = cfg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cmd_q       <= '0;
      cfg_q       <= 1'b0;
      digital_q   <= 1'b0;
      frame_len_q <= FullLen;
      table_q     <= TABLE_RESET;
    end else if (step_i) begin
      pos_q       <= pos_d;
      cmd_q       <= cmd_d;
      cfg_q       <= cfg_d;
      digital_q   <= digital_d;
      frame_len_q <= frame_len_d;
      table_q     <= table_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 1'b0;
    end else if (cfg_we_i) begin
      allow_q <= cfg_data_i;
    end
  end

endmodule

// ----- sv/gsp_out_stage.sv -----
// ----------------------------------------------------------------------------
// gsp_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module gsp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  gsp_pkg::gsp_result_t result_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gsp_pkg::gsp_result_t result_o
);
  import gsp_pkg::*;

  logic        valid_q;
  gsp_result_t result_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ----- sv/gamepad_spi_poll_responder.sv -----
// Path: an accepted item waits in the input register, then its combinational decode
//   of position and command is loaded into the result register at the output port.
// Throughput: one item per cycle while the output is not stalled.
// Data updates give no result. Reset is asynchronous: frame position 0,
//   analog mode, config mode off, reply table at idle buttons and centered sticks.
// ----------------------------------------------------------------------------
// gamepad_spi_poll_responder
// Device side of a console gamepad poll exchange: reply byte and ack per byte, no ack on a frame's last byte.
// ----------------------------------------------------------------------------
module gamepad_spi_poll_responder #(
  parameter int FULL_LENGTH = 21
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [7:0] buttons_low_i,
  input  logic [7:0] buttons_high_i,
  input  logic [7:0] right_stick_x_i,
  input  logic [7:0] right_stick_y_i,
  input  logic [7:0] left_stick_x_i,
  input  logic [7:0] left_stick_y_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] reply_byte_o,
  output logic       reply_load_o,
  output logic       ack_pulse_o,
  output logic [4:0] frame_index_o,
  output logic       in_config_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);
  import gsp_pkg::*;

  gsp_item_t   item_in, item_q;
  gsp_result_t eng_result, out_result;
  logic        item_valid;
  logic        has_result;
  logic        out_ready;
  logic        advance;

  assign item_in = '{opcode:        gsp_op_e'(opcode_i),
                     cmd_byte:      cmd_byte_i,
                     buttons_low:   buttons_low_i,
                     buttons_high:  buttons_high_i,
                     right_stick_x: right_stick_x_i,
                     right_stick_y: right_stick_y_i,
                     left_stick_x:  left_stick_x_i,
                     left_stick_y:  left_stick_y_i};

  // an item without a result never waits on the output side
  assign advance     = item_valid && (!has_result || out_ready);
  assign cfg_ready_o = 1'b1;

  gsp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .take_i     (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  gsp_engine #(
    .FULL_LENGTH (FULL_LENGTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (item_q),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .has_result_o (has_result),
    .result_o     (eng_result)
  );

  gsp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .result_i    (eng_result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign reply_byte_o  = out_result.reply_byte;
  assign reply_load_o  = out_result.reply_load;
  assign ack_pulse_o   = out_result.ack_pulse;
  assign frame_index_o = out_result.frame_index;
  assign in_config_o   = out_result.in_config;

`ifndef SYNTHESIS
  // a result never overwrites one the consumer is still stalling on
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && has_result |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  a_ack_needs_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ack_pulse_o |-> reply_load_o)
    else $error("acknowledge without a loaded reply");

  a_no_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reply_load_o |-> (reply_byte_o == 8'h00) && !ack_pulse_o)
    else $error("unloaded result carries data");
`endif

endmodule
